[sv/tsg_pkg.sv]
// shared widths, register indexes and types of the trapezoidal setpoint generator
package tsg_pkg;

  // fixed point format and data widths
  localparam int DW        = 32;
  localparam int FRAC_BITS = 16;
  localparam int TW        = DW + FRAC_BITS;       // tau and cruise end time
  localparam int QW        = DW + 2 * FRAC_BITS;   // scaled distance over accel
  localparam int RW        = QW / 2;               // peak time of a triangle move
  localparam int CW        = TW + 1;               // width of time compares
  localparam int SQW       = 2 * DW;               // square of a time
  localparam int PW        = 3 * DW;               // accel times a square
  localparam int XW        = 2 * DW - FRAC_BITS;   // velocity times time, scaled
  localparam int CAP_W     = XW + 1;               // saturated square term
  localparam int SH_HALF   = 2 * FRAC_BITS + 1;
  localparam int SH_FULL   = 2 * FRAC_BITS;
  localparam int TDATA_IN_W  = 3 * DW;
  localparam int TDATA_OUT_W = DW;

  // configuration registers
  localparam int IDX_W = 1;
  localparam logic [IDX_W-1:0] REG_MAX_ACCEL    = 1'b0;
  localparam logic [IDX_W-1:0] REG_MAX_VELOCITY = 1'b1;
  localparam logic [DW-1:0]    LIMIT_RST        = DW'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    PH_RISE,
    PH_CRUISE,
    PH_DECEL,
    PH_FALL,
    PH_DONE
  } tsg_phase_e;

  // per-item data carried beside the dividers and the root unit
  typedef struct packed {
    logic          eq;
    logic          neg;
    logic [DW-1:0] qi;
    logic [DW-1:0] span;
    logic [DW-1:0] a;
    logic [DW-1:0] v;
    logic [DW-1:0] t;
  } tsg_side_t;

  typedef struct packed {
    tsg_side_t     side;
    logic [TW-1:0] tau;
    logic [TW-1:0] tcr;
    logic [RW-1:0] tp;
  } tsg_prof_t;

  typedef struct packed {
    logic          eq;
    logic          neg;
    logic [DW-1:0] qi;
    logic [DW-1:0] disp;
  } tsg_res_t;

endpackage

[sv/tsg_div.sv]
// pipelined restoring divider, one quotient bit per stage
module tsg_div
  import tsg_pkg::*;
#(
  parameter int N = QW
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [N-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [N-1:0] quo_o
);

  logic [DW-1:0] rem_q [N];
  logic [N-1:0]  num_q [N];
  logic [DW-1:0] den_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [N-1:0]  num_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, num_in[N-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= {1'b0, den_in}) begin
          rem_q[k] <= diff[DW-1:0];
          num_q[k] <= {num_in[N-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[DW-1:0];
          num_q[k] <= {num_in[N-2:0], 1'b0};
        end
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = num_q[N-1];

endmodule

[sv/tsg_sqrt.sv]
// pipelined integer square root, one root bit per stage
module tsg_sqrt
  import tsg_pkg::*;
#(
  parameter int W = RW
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] rad_i,
  output logic [W-1:0]   root_o
);

  logic [W+1:0]   rem_q  [W];
  logic [W-1:0]   root_q [W];
  logic [2*W-1:0] rad_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W+1:0]   rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] rad_in;
    logic [W+3:0]   cur;
    logic [W+3:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign cur   = {rem_in, rad_in[2*W-1:2*W-2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          rem_q[k]  <= (W+2)'(cur - trial);
          root_q[k] <= {root_in[W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[W+1:0];
          root_q[k] <= {root_in[W-2:0], 1'b0};
        end
        rad_q[k] <= {rad_in[2*W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[W-1];

endmodule

[sv/tsg_profile.sv]
// phase select, square terms and displacement of the motion profile
module tsg_profile
  import tsg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  tsg_prof_t item_i,
  output logic      valid_o,
  output tsg_res_t  res_o
);

  localparam int NSTG = 8;
  localparam logic [PW-1:0] CAP = PW'({CAP_W{1'b1}});

  function automatic logic [CAP_W-1:0] sat_term(logic [PW-1:0] p, logic full);
    logic [PW-1:0] s;
    s = full ? (p >> SH_FULL) : (p >> SH_HALF);
    return (s > CAP) ? CAP[CAP_W-1:0] : s[CAP_W-1:0];
  endfunction

  logic [NSTG-1:0] vld_q;

  // stage 1: time compares
  tsg_prof_t c1_q;
  logic c1_trap_q, c1_le_tau_q, c1_le_tcr_q, c1_le_end_q, c1_le_tp_q, c1_le_2tp_q;
  // stage 2: phase and square operands
  tsg_side_t  c2_side_q;
  tsg_phase_e c2_ph_q, c2_ph_d;
  logic       c2_full_q;
  logic [DW-1:0] c2_xa_q, c2_xa_d, c2_xb_q;
  // stage 3: squares and velocity term
  tsg_side_t  c3_side_q;
  tsg_phase_e c3_ph_q;
  logic       c3_full_q;
  logic [SQW-1:0] c3_sqa_q, c3_sqb_q, c3_vt_q;
  // stage 4: partial products
  tsg_side_t  c4_side_q;
  tsg_phase_e c4_ph_q;
  logic       c4_full_q;
  logic [2*DW-1:0] c4_pla_q, c4_pha_q, c4_plb_q, c4_phb_q;
  logic [XW-1:0]   c4_x_q;
  // stage 5: full products
  tsg_side_t  c5_side_q;
  tsg_phase_e c5_ph_q;
  logic       c5_full_q;
  logic [PW-1:0] c5_pa_q, c5_pb_q;
  logic [XW-1:0] c5_x_q;
  // stage 6: scaled, saturated square terms
  tsg_side_t  c6_side_q;
  tsg_phase_e c6_ph_q;
  logic [CAP_W-1:0] c6_ha_q, c6_hb_q;
  logic [XW-1:0]    c6_x_q;
  // stage 7: raw displacement
  tsg_side_t  c7_side_q;
  logic [CAP_W-1:0] c7_raw_q, c7_raw_d;
  // stage 8: clamped displacement
  tsg_res_t c8_q;

  logic [CW-1:0]    tt, tsum;
  logic [CAP_W:0]   hsum;
  logic [CAP_W-1:0] xe;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  assign tt   = CW'(item_i.side.t);
  assign tsum = CW'(item_i.tcr) + CW'(item_i.tau);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q        <= item_i;
      c1_trap_q   <= item_i.tcr > item_i.tau;
      c1_le_tau_q <= tt <= CW'(item_i.tau);
      c1_le_tcr_q <= tt <= CW'(item_i.tcr);
      c1_le_end_q <= tt <= tsum;
      c1_le_tp_q  <= tt <= CW'(item_i.tp);
      c1_le_2tp_q <= tt <= CW'({item_i.tp, 1'b0});
    end
  end

  always_comb begin
    c2_ph_d = PH_DONE;
    c2_xa_d = c1_q.side.t;
    if (c1_trap_q) begin
      if (c1_le_tau_q) begin
        c2_ph_d = PH_RISE;
      end else if (c1_le_tcr_q) begin
        c2_ph_d = PH_CRUISE;
      end else if (c1_le_end_q) begin
        c2_ph_d = PH_DECEL;
        c2_xa_d = c1_q.side.t - c1_q.tcr[DW-1:0];
      end
    end else begin
      if (c1_le_tp_q) begin
        c2_ph_d = PH_RISE;
      end else if (c1_le_2tp_q) begin
        c2_ph_d = PH_FALL;
        c2_xa_d = DW'({c1_q.tp, 1'b0}) - c1_q.side.t;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2_side_q <= c1_q.side;
      c2_ph_q   <= c2_ph_d;
      c2_full_q <= !c1_trap_q;
      c2_xa_q   <= c2_xa_d;
      c2_xb_q   <= c1_trap_q ? c1_q.tau[DW-1:0] : DW'(c1_q.tp);

      c3_side_q <= c2_side_q;
      c3_ph_q   <= c2_ph_q;
      c3_full_q <= c2_full_q;
      c3_sqa_q  <= SQW'(c2_xa_q) * SQW'(c2_xa_q);
      c3_sqb_q  <= SQW'(c2_xb_q) * SQW'(c2_xb_q);
      c3_vt_q   <= SQW'(c2_side_q.v) * SQW'(c2_side_q.t);

      c4_side_q <= c3_side_q;
      c4_ph_q   <= c3_ph_q;
      c4_full_q <= c3_full_q;
      c4_pla_q  <= (2*DW)'(c3_side_q.a) * (2*DW)'(c3_sqa_q[DW-1:0]);
      c4_pha_q  <= (2*DW)'(c3_side_q.a) * (2*DW)'(c3_sqa_q[SQW-1:DW]);
      c4_plb_q  <= (2*DW)'(c3_side_q.a) * (2*DW)'(c3_sqb_q[DW-1:0]);
      c4_phb_q  <= (2*DW)'(c3_side_q.a) * (2*DW)'(c3_sqb_q[SQW-1:DW]);
      c4_x_q    <= c3_vt_q[SQW-1:FRAC_BITS];

      c5_side_q <= c4_side_q;
      c5_ph_q   <= c4_ph_q;
      c5_full_q <= c4_full_q;
      c5_pa_q   <= PW'(c4_pla_q) + (PW'(c4_pha_q) << DW);
      c5_pb_q   <= PW'(c4_plb_q) + (PW'(c4_phb_q) << DW);
      c5_x_q    <= c4_x_q;

      c6_side_q <= c5_side_q;
      c6_ph_q   <= c5_ph_q;
      c6_ha_q   <= sat_term(c5_pa_q, 1'b0);
      c6_hb_q   <= sat_term(c5_pb_q, c5_full_q);
      c6_x_q    <= c5_x_q;
    end
  end

  assign xe   = CAP_W'(c6_x_q);
  assign hsum = (CAP_W+1)'(c6_ha_q) + (CAP_W+1)'(c6_hb_q);

  always_comb begin
    case (c6_ph_q)
      PH_RISE:   c7_raw_d = c6_ha_q;
      PH_CRUISE: c7_raw_d = (xe > c6_hb_q) ? xe - c6_hb_q : '0;
      PH_DECEL:  c7_raw_d = ((CAP_W+1)'(xe) > hsum) ? CAP_W'((CAP_W+1)'(xe) - hsum) : '0;
      PH_FALL:   c7_raw_d = (c6_hb_q > c6_ha_q) ? c6_hb_q - c6_ha_q : '0;
      default:   c7_raw_d = CAP_W'(c6_side_q.span);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c7_side_q <= c6_side_q;
      c7_raw_q  <= c7_raw_d;

      c8_q.eq   <= c7_side_q.eq;
      c8_q.neg  <= c7_side_q.neg;
      c8_q.qi   <= c7_side_q.qi;
      c8_q.disp <= (c7_raw_q > CAP_W'(c7_side_q.span)) ? c7_side_q.span
                                                       : c7_raw_q[DW-1:0];
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign res_o   = c8_q;

endmodule

[sv/trapezoidal_setpoint_generator_top.sv]
// top level of the trapezoidal position setpoint generator
//
// Gives the position setpoint of a rest-to-rest move from start to target at a
// given elapsed time, limited by max_accel and max_velocity (unsigned Q16.16).
// Long moves follow accelerate / cruise / decelerate, short ones a triangle
// whose peak time is the square root of distance over acceleration. Each beat
// stands alone, so beats stream at one per cycle unless the result side stalls.
// The path is an input register, three parallel 64-stage bit-per-stage
// dividers (accel time, cruise end, distance over accel), a 32-stage
// bit-per-stage square root for the peak time, eight stages of phase select,
// multiplies and clamping, and the output register. A stall on the result
// side freezes the whole pipeline; nothing is dropped or repeated.
// Configuration writes take effect at once and should be issued only while
// the pipeline is empty.
module trapezoidal_setpoint_generator_top
  import tsg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_idx_i,
  input  logic [DW-1:0]          cfg_data_i,
  // input beats
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // start_position, target_position, elapsed_time
  // result beats
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata   // setpoint
);

  logic en;

  // limit registers
  logic [DW-1:0] accel_q, vel_q;

  // input stage
  logic          s0_vld_q;
  tsg_side_t     s0_q, s0_d;
  logic [DW-1:0] qi, qf;
  logic [DW:0]   diff;

  // sideband beside dividers and root
  logic      dv_vld_q [QW];
  tsg_side_t dv_side_q [QW];
  logic      rt_vld_q [RW];
  tsg_side_t rt_side_q [RW];
  logic [TW-1:0] rt_tau_q [RW];
  logic [TW-1:0] rt_tcr_q [RW];

  logic [QW-1:0] tau_quo, tcr_quo, pk_quo;
  logic [RW-1:0] tp;
  tsg_prof_t     prof_in;
  logic          prof_vld;
  tsg_res_t      prof_res;

  // output register
  logic          out_vld_q;
  logic [DW-1:0] out_data_q, out_data_d;

  // whole pipeline moves unless a finished result is held
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= LIMIT_RST;
      vel_q   <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_ACCEL:    accel_q <= cfg_data_i;
        REG_MAX_VELOCITY: vel_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // distance and direction of the move; zero limits act as the smallest step
  assign qi   = s_axis_tdata[DW-1:0];
  assign qf   = s_axis_tdata[2*DW-1:DW];
  assign diff = {qf[DW-1], qf} - {qi[DW-1], qi};

  always_comb begin
    s0_d.eq   = qi == qf;
    s0_d.neg  = diff[DW];
    s0_d.qi   = qi;
    s0_d.span = diff[DW] ? DW'(-diff) : diff[DW-1:0];
    s0_d.a    = (accel_q == '0) ? DW'(1) : accel_q;
    s0_d.v    = (vel_q == '0) ? DW'(1) : vel_q;
    s0_d.t    = s_axis_tdata[3*DW-1:2*DW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
    end
  end

  // accel time v/a, cruise end dist/v, and dist/a for the triangle peak
  tsg_div #(.N(QW)) u_div_tau (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (QW'({s0_q.v, {FRAC_BITS{1'b0}}})),
    .den_i (s0_q.a),
    .quo_o (tau_quo)
  );

  tsg_div #(.N(QW)) u_div_tcr (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (QW'({s0_q.span, {FRAC_BITS{1'b0}}})),
    .den_i (s0_q.v),
    .quo_o (tcr_quo)
  );

  tsg_div #(.N(QW)) u_div_pk (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({s0_q.span, {(2*FRAC_BITS){1'b0}}}),
    .den_i (s0_q.a),
    .quo_o (pk_quo)
  );

  // floor(sqrt(floor(x/a))) is the largest r with a*r*r <= x
  tsg_sqrt #(.W(RW)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (pk_quo),
    .root_o (tp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) dv_vld_q[i] <= 1'b0;
      for (int i = 0; i < RW; i++) rt_vld_q[i] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= s0_vld_q;
      for (int i = 1; i < QW; i++) dv_vld_q[i] <= dv_vld_q[i-1];
      rt_vld_q[0] <= dv_vld_q[QW-1];
      for (int i = 1; i < RW; i++) rt_vld_q[i] <= rt_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_side_q[0] <= s0_q;
      for (int i = 1; i < QW; i++) dv_side_q[i] <= dv_side_q[i-1];
      rt_side_q[0] <= dv_side_q[QW-1];
      rt_tau_q[0]  <= tau_quo[TW-1:0];
      rt_tcr_q[0]  <= tcr_quo[TW-1:0];
      for (int i = 1; i < RW; i++) begin
        rt_side_q[i] <= rt_side_q[i-1];
        rt_tau_q[i]  <= rt_tau_q[i-1];
        rt_tcr_q[i]  <= rt_tcr_q[i-1];
      end
    end
  end

  always_comb begin
    prof_in.side = rt_side_q[RW-1];
    prof_in.tau  = rt_tau_q[RW-1];
    prof_in.tcr  = rt_tcr_q[RW-1];
    prof_in.tp   = tp;
  end

  tsg_profile u_profile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_vld_q[RW-1]),
    .item_i  (prof_in),
    .valid_o (prof_vld),
    .res_o   (prof_res)
  );

  // setpoint lies between start and target, so no saturation is needed
  always_comb begin
    if (prof_res.eq) begin
      out_data_d = prof_res.qi;
    end else if (prof_res.neg) begin
      out_data_d = prof_res.qi - prof_res.disp;
    end else begin
      out_data_d = prof_res.qi + prof_res.disp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= prof_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
